/* hw/rtl/gfr_pkg.sv */
`default_nettype none

package gfr_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN = 14;
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
	localparam logic [POS_W-1:0] POS_CODE = 4'd2;
	localparam logic [POS_W-1:0] POS_ID = 4'd3;
	localparam logic [POS_W-1:0] POS_DATA_FIRST = 4'd4;
	localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd11;
	localparam logic [7:0] HEADER_MARK = 8'h7a;
	localparam logic [7:0] DPAD_MASK = 8'h0f;

	// Frame status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
	localparam logic [1:0] STATUS_BAD_CHECKSUM = 2'd2;

	localparam int unsigned PAD_BYTES = 8;
	localparam int unsigned RESULT_W = 82;
	localparam int unsigned M_TDATA_W = 88;

	typedef logic [PAD_BYTES-1:0][7:0] pad_bytes_t;

	// Declared high field first so status lands in the lowest bits
	typedef struct packed {
		logic [7:0] right_trigger;
		logic [7:0] left_trigger;
		logic [7:0] right_y;
		logic [7:0] right_x;
		logic [7:0] left_y;
		logic [7:0] left_x;
		logic [7:0] buttons_lower;
		logic [7:0] buttons_upper;
		logic [7:0] controller_id;
		logic [7:0] message_code;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/gfr_report_map.sv */
`default_nettype none

module gfr_report_map (
	input  wire logic [7:0] pad0,
	input  wire logic [7:0] pad1,
	output logic [7:0]      buttons_upper,
	output logic [7:0]      buttons_lower
);

	// Upper byte: stick clicks, select, start, d-pad nibble
	always_comb begin
		buttons_upper = {pad1[7], pad1[6], pad0[5], pad0[4], 4'b0000}
			| (pad1 & gfr_pkg::DPAD_MASK);
	end

	// Lower byte: Y, X, B, A, zero, guide, R1, L1 from the top down
	always_comb begin
		buttons_lower = {pad0[0], pad0[3], pad0[1], pad0[2], 1'b0,
			pad0[5] & pad0[4], pad0[7], pad0[6]};
	end

endmodule

`default_nettype wire

/* hw/rtl/gfr_frame_assembler.sv */
`default_nettype none

module gfr_frame_assembler (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             restart,
	output logic                  last,
	output gfr_pkg::result_t      result
);

	logic [gfr_pkg::POS_W-1:0] pos_q;
	logic [7:0]                csum_q;
	logic [7:0]                header_q;
	logic [7:0]                code_q;
	logic [7:0]                id_q;
	gfr_pkg::pad_bytes_t       staging_q;
	gfr_pkg::pad_bytes_t       pad_q;

	logic [gfr_pkg::POS_W-1:0] pos_eff;
	logic [gfr_pkg::POS_W-1:0] data_off;
	logic [2:0]                stage_idx;
	logic [7:0]                csum_eff;
	logic                      begin_frame;
	logic [1:0]                status;
	logic                      commit;
	gfr_pkg::pad_bytes_t       pad_next;
	logic [7:0]                upper;
	logic [7:0]                lower;

	// Restart or an out-of-range position starts a fresh frame
	assign begin_frame = restart || (pos_q >= gfr_pkg::POS_W'(gfr_pkg::FRAME_LEN));
	assign pos_eff = begin_frame ? '0 : pos_q;
	assign csum_eff = begin_frame ? 8'h00 : csum_q;
	assign last = (pos_eff == gfr_pkg::POS_LAST);
	assign data_off = pos_eff - gfr_pkg::POS_DATA_FIRST;
	assign stage_idx = data_off[2:0];

	// Judge the frame on its final word; header fault wins
	always_comb begin
		priority if (header_q != gfr_pkg::HEADER_MARK) begin
			status = gfr_pkg::STATUS_BAD_HEADER;
		end else if (rx_byte != csum_eff) begin
			status = gfr_pkg::STATUS_BAD_CHECKSUM;
		end else begin
			status = gfr_pkg::STATUS_OK;
		end
	end

	assign commit = (status == gfr_pkg::STATUS_OK);
	assign pad_next = commit ? staging_q : pad_q;

	// Advance position and checksum, capture frame bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			csum_q <= '0;
			header_q <= '0;
			code_q <= '0;
			id_q <= '0;
			staging_q <= '0;
			pad_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q <= '0;
				csum_q <= '0;
				pad_q <= pad_next;
			end else begin
				pos_q <= pos_eff + 1'b1;
				csum_q <= csum_eff ^ rx_byte;
				if (pos_eff == gfr_pkg::POS_HEADER) begin
					header_q <= rx_byte;
				end
				if (pos_eff == gfr_pkg::POS_CODE) begin
					code_q <= rx_byte;
				end
				if (pos_eff == gfr_pkg::POS_ID) begin
					id_q <= rx_byte;
				end
				if (pos_eff >= gfr_pkg::POS_DATA_FIRST && pos_eff <= gfr_pkg::POS_DATA_LAST) begin
					staging_q[stage_idx] <= rx_byte;
				end
			end
		end
	end

	gfr_report_map u_map (
		.pad0          (pad_next[0]),
		.pad1          (pad_next[1]),
		.buttons_upper (upper),
		.buttons_lower (lower)
	);

	// Build the report from the state as it stands after this frame
	always_comb begin
		result.status = status;
		result.message_code = code_q;
		result.controller_id = id_q;
		result.buttons_upper = upper;
		result.buttons_lower = lower;
		result.left_x = pad_next[2];
		result.left_y = pad_next[3];
		result.right_x = pad_next[4];
		result.right_y = pad_next[5];
		result.left_trigger = pad_next[6];
		result.right_trigger = pad_next[7];
	end

endmodule

`default_nettype wire

/* hw/rtl/gamepad_frame_receiver.sv */
// Path: the frame's 14th byte passes through the input register, and once the assembler takes it
// the report word is loaded into the output register that drives m_tdata.
// Throughput: one byte per cycle, set by the input register feeding a single frame-update step,
// except while a held report stalls the next frame's 14th byte and the input behind it.
// Reset (arst_n low, asynchronous): position, checksum, captured bytes and pad state clear to
// zero (pad at rest); no word is pending on either side.
`default_nettype none

module gamepad_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic        s_tuser,  // [0] restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [9:2] message_code, [17:10] controller_id, [25:18] buttons_upper,
	// [33:26] buttons_lower, [41:34] left_x, [49:42] left_y, [57:50] right_x,
	// [65:58] right_y, [73:66] left_trigger, [81:74] right_trigger, [87:82] zero
	output logic [gfr_pkg::M_TDATA_W-1:0] m_tdata
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             restart_s1;
	logic             last;
	logic             advance;
	logic             out_valid_q;
	gfr_pkg::result_t result;
	gfr_pkg::result_t result_q;

	// A non-final word always moves on; the final word needs a free output slot
	assign advance = valid_s1 && (!last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	gfr_frame_assembler u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.rx_byte (byte_s1),
		.restart (restart_s1),
		.last    (last),
		.result  (result)
	);

	// Output register: load a finished report, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(gfr_pkg::M_TDATA_W - gfr_pkg::RESULT_W)'(0), result_q};

endmodule

`default_nettype wire

/* hw/rtl/gfr_checker.sv */
`default_nettype none

module gfr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [gfr_pkg::M_TDATA_W-1:0] m_tdata
);

	// Hold a stalled report word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("report word changed while stalled");

	// Status is one of the three defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == gfr_pkg::STATUS_OK
			|| m_tdata[1:0] == gfr_pkg::STATUS_BAD_HEADER
			|| m_tdata[1:0] == gfr_pkg::STATUS_BAD_CHECKSUM))
		else $error("undefined frame status");

	// Guide follows start and select, spare bit and padding stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28] == (m_tdata[22] & m_tdata[23]))
		else $error("guide bit disagrees with start and select");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[29] && m_tdata[87:82] == 6'd0)
		else $error("reserved report bits set");

endmodule

bind gamepad_frame_receiver gfr_checker u_gfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
